// ===== src/dmfd_pkg.sv =====
// shared types, register indexes and reset values for the dual marker frame deframer
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package dmfd_pkg;

    // marker length in bytes, default for the top level parameter
    localparam int MARKER_BYTES_DEF = 4;

    // configuration port geometry
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STATUS_START  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STATUS_END    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COMMAND_START = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COMMAND_END   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH_LE     = 3'd4;

    // configuration reset values
    localparam logic [31:0] STATUS_START_RST  = 32'hF1F2_F3F4;
    localparam logic [31:0] STATUS_END_RST    = 32'hF5F6_F7F8;
    localparam logic [31:0] COMMAND_START_RST = 32'hFAFB_FCFD;
    localparam logic [31:0] COMMAND_END_RST   = 32'h0102_0304;
    localparam logic        LENGTH_LE_RST     = 1'b1;

    // parser phases
    typedef enum logic [2:0] {
        PH_HUNT,
        PH_LEN_A,
        PH_LEN_B,
        PH_DATA,
        PH_END
    } t_phase;

    // result event codes
    typedef enum logic [1:0] {
        EV_PAYLOAD  = 2'd0,
        EV_COMPLETE = 2'd1,
        EV_DROPPED  = 2'd2
    } t_event;

    // configuration registers as seen by the parser
    typedef struct packed {
        logic [31:0] status_start;
        logic [31:0] status_end;
        logic [31:0] command_start;
        logic [31:0] command_end;
        logic        length_le;
    } t_cfg;

    // one result word
    typedef struct packed {
        t_event      kind;
        logic [7:0]  payload_byte;
        logic        status_frame;
        logic [15:0] payload_length;
        logic        frame_last;
    } t_result;

    // byte of a marker, first received byte in bits 7:0
    function automatic logic [7:0] marker_byte(input logic [31:0] marker,
                                               input logic [1:0]  pos);
        return marker[{pos, 3'b000} +: 8];
    endfunction

endpackage

// ===== src/dmfd_cfg_regs.sv =====
// configuration register file: marker values and length byte order
// depends on dmfd_pkg
`timescale 1ns / 1ps

module dmfd_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [dmfd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [dmfd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output dmfd_pkg::t_cfg                 o_cfg
);
    import dmfd_pkg::*;

    t_cfg r_cfg;

    // register writes, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.status_start  <= STATUS_START_RST;
            r_cfg.status_end    <= STATUS_END_RST;
            r_cfg.command_start <= COMMAND_START_RST;
            r_cfg.command_end   <= COMMAND_END_RST;
            r_cfg.length_le     <= LENGTH_LE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_STATUS_START:  r_cfg.status_start  <= i_cfg_data;
                REG_STATUS_END:    r_cfg.status_end    <= i_cfg_data;
                REG_COMMAND_START: r_cfg.command_start <= i_cfg_data;
                REG_COMMAND_END:   r_cfg.command_end   <= i_cfg_data;
                REG_LENGTH_LE:     r_cfg.length_le     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== src/dmfd_parser.sv =====
// frame parser: marker hunt, length capture, payload count and end marker check
// depends on dmfd_pkg
`timescale 1ns / 1ps

module dmfd_parser #(
    parameter int MARKER_BYTES = dmfd_pkg::MARKER_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_rx_byte,
    input  dmfd_pkg::t_cfg    i_cfg,
    output logic              o_res_valid,
    output dmfd_pkg::t_result o_result
);
    import dmfd_pkg::*;

    localparam int CNT_W = $clog2(MARKER_BYTES + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MARKER_BYTES);

    t_phase           r_phase, n_phase;
    logic [CNT_W-1:0] r_s_cnt, n_s_cnt;
    logic [CNT_W-1:0] r_c_cnt, n_c_cnt;
    logic [CNT_W-1:0] r_e_cnt, n_e_cnt;
    logic             r_is_status, n_is_status;
    logic [15:0]      r_length, n_length;
    logic [15:0]      r_count, n_count;

    logic [1:0]       w_s_pos, w_c_pos, w_e_pos;
    logic [CNT_W-1:0] w_s_inc, w_c_inc, w_e_inc;
    logic [15:0]      w_count_inc;
    logic [31:0]      w_end_marker;
    logic             w_s_hit, w_c_hit, w_e_hit;

    // marker compares for the current counts
    always_comb begin
        w_s_pos      = 2'(r_s_cnt);
        w_c_pos      = 2'(r_c_cnt);
        w_e_pos      = 2'(r_e_cnt);
        w_s_inc      = r_s_cnt + 1'b1;
        w_c_inc      = r_c_cnt + 1'b1;
        w_e_inc      = r_e_cnt + 1'b1;
        w_count_inc  = r_count + 16'd1;
        w_end_marker = r_is_status ? i_cfg.status_end : i_cfg.command_end;
        w_s_hit = (r_s_cnt < CNT_FULL) &&
                  (i_rx_byte == marker_byte(i_cfg.status_start, w_s_pos));
        w_c_hit = (r_c_cnt < CNT_FULL) &&
                  (i_rx_byte == marker_byte(i_cfg.command_start, w_c_pos));
        w_e_hit = (r_e_cnt < CNT_FULL) &&
                  (i_rx_byte == marker_byte(w_end_marker, w_e_pos));
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT;
            r_s_cnt     <= '0;
            r_c_cnt     <= '0;
            r_e_cnt     <= '0;
            r_is_status <= 1'b0;
            r_length    <= '0;
            r_count     <= '0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_s_cnt     <= n_s_cnt;
            r_c_cnt     <= n_c_cnt;
            r_e_cnt     <= n_e_cnt;
            r_is_status <= n_is_status;
            r_length    <= n_length;
            r_count     <= n_count;
        end
    end

    // next state and result for the current word
    always_comb begin
        n_phase     = r_phase;
        n_s_cnt     = r_s_cnt;
        n_c_cnt     = r_c_cnt;
        n_e_cnt     = r_e_cnt;
        n_is_status = r_is_status;
        n_length    = r_length;
        n_count     = r_count;

        o_res_valid             = 1'b0;
        o_result.kind           = EV_PAYLOAD;
        o_result.payload_byte   = 8'd0;
        o_result.status_frame   = r_is_status;
        o_result.payload_length = r_length;
        o_result.frame_last     = 1'b0;

        unique case (r_phase)
            PH_HUNT: begin
                // status marker wins when both could advance
                if (w_s_hit) begin
                    n_s_cnt = w_s_inc;
                    n_c_cnt = '0;
                    if (w_s_inc == CNT_FULL) begin
                        n_phase     = PH_LEN_A;
                        n_is_status = 1'b1;
                        n_s_cnt     = '0;
                        n_e_cnt     = '0;
                        n_length    = '0;
                        n_count     = '0;
                    end
                end else if (w_c_hit) begin
                    n_c_cnt = w_c_inc;
                    n_s_cnt = '0;
                    if (w_c_inc == CNT_FULL) begin
                        n_phase     = PH_LEN_A;
                        n_is_status = 1'b0;
                        n_c_cnt     = '0;
                        n_e_cnt     = '0;
                        n_length    = '0;
                        n_count     = '0;
                    end
                end else begin
                    n_s_cnt = '0;
                    n_c_cnt = '0;
                end
            end
            PH_LEN_A: begin
                n_length = i_cfg.length_le ? {8'd0, i_rx_byte} : {i_rx_byte, 8'd0};
                n_phase  = PH_LEN_B;
            end
            PH_LEN_B: begin
                n_length = r_length |
                           (i_cfg.length_le ? {i_rx_byte, 8'd0} : {8'd0, i_rx_byte});
                n_count  = '0;
                // zero length skips the payload
                n_phase  = (n_length == 16'd0) ? PH_END : PH_DATA;
            end
            PH_DATA: begin
                n_count = w_count_inc;
                if (w_count_inc == r_length) begin
                    n_phase = PH_END;
                end
                o_res_valid           = 1'b1;
                o_result.kind         = EV_PAYLOAD;
                o_result.payload_byte = i_rx_byte;
            end
            PH_END: begin
                if (w_e_hit && (w_e_inc != CNT_FULL)) begin
                    n_e_cnt = w_e_inc;
                end else begin
                    // frame finished either way, back to hunting
                    o_res_valid         = 1'b1;
                    o_result.kind       = w_e_hit ? EV_COMPLETE : EV_DROPPED;
                    o_result.frame_last = 1'b1;
                    n_phase     = PH_HUNT;
                    n_s_cnt     = '0;
                    n_c_cnt     = '0;
                    n_e_cnt     = '0;
                    n_is_status = 1'b0;
                    n_length    = '0;
                    n_count     = '0;
                end
            end
            default: begin
                n_phase = PH_HUNT;
            end
        endcase
    end

endmodule

// ===== src/dmfd_out_reg.sv =====
// result register on the output channel, holds a word while stalled
// depends on dmfd_pkg
`timescale 1ns / 1ps

module dmfd_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  dmfd_pkg::t_result i_result,
    input  logic              i_stall,
    output logic              o_valid,
    output dmfd_pkg::t_result o_result
);
    import dmfd_pkg::*;

    logic    r_valid;
    t_result r_result;

    // valid flag: set on load, cleared when the word is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ===== src/dual_marker_frame_deframer.sv =====
// Dual marker frame deframer. Takes one received byte per word, hunts for a status or a
// command start marker, reads a 16-bit length, passes each payload byte out as it arrives
// and checks the matching end marker, reporting the frame complete or dropped. One byte
// can be accepted every cycle. An accepted byte sits in the input register and is parsed
// from there; its result, if any, is loaded into the result register as the byte moves
// on. While a result word waits on a stalled output, the byte behind it is held and the
// input stalls until the result word is taken. Start marker, length and leading end
// marker bytes produce no result word. Configuration writes take effect at once.
// depends on dmfd_pkg, dmfd_cfg_regs, dmfd_parser, dmfd_out_reg
`timescale 1ns / 1ps

module dual_marker_frame_deframer #(
    parameter int MARKER_BYTES = dmfd_pkg::MARKER_BYTES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [dmfd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [dmfd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input channel
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [7:0]                      i_rx_byte,
    // output channel
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [1:0]                      o_event_kind,
    output logic [7:0]                      o_payload_byte,
    output logic                            o_status_frame,
    output logic [15:0]                     o_payload_length,
    output logic                            o_frame_last
);
    import dmfd_pkg::*;

    t_cfg       w_cfg;
    t_result    w_result;
    t_result    w_out;
    logic       w_res_valid;
    logic       w_advance;
    logic       w_accept;
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // configuration registers
    dmfd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // input word moves on when the result register is free or being drained
    assign w_advance = r_in_valid && (!o_valid || !i_stall);
    assign o_stall   = r_in_valid && !w_advance;
    assign w_accept  = i_valid && !o_stall;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // frame parser
    dmfd_parser #(
        .MARKER_BYTES (MARKER_BYTES)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_advance),
        .i_rx_byte   (r_in_byte),
        .i_cfg       (w_cfg),
        .o_res_valid (w_res_valid),
        .o_result    (w_result)
    );

    // result register
    dmfd_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_advance && w_res_valid),
        .i_result (w_result),
        .i_stall  (i_stall),
        .o_valid  (o_valid),
        .o_result (w_out)
    );

    // output fields
    assign o_event_kind     = w_out.kind;
    assign o_payload_byte   = w_out.payload_byte;
    assign o_status_frame   = w_out.status_frame;
    assign o_payload_length = w_out.payload_length;
    assign o_frame_last     = w_out.frame_last;

endmodule

// ===== test/dual_marker_frame_deframer_tb.sv =====
// testbench for dual_marker_frame_deframer: directed frames, back-pressure, random traffic
// over several register setups and a frame with a large length, checked word by word
// depends on dmfd_pkg and the deframer rtl
`timescale 1ns / 1ps

module dual_marker_frame_deframer_tb;
    import dmfd_pkg::*;

    localparam int MARKER_LEN     = MARKER_BYTES_DEF;
    localparam int SETTLE_CYCLES  = 4;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_WORDS   = 1100;
    localparam int TRAFFIC_SETUPS = 5;
    localparam int LONG_PART      = 48;

    // receiver stall patterns
    typedef enum logic [1:0] {
        RX_FREE,
        RX_RANDOM,
        RX_PATTERN,
        RX_HEAVY
    } t_rx_mode;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_valid     = 1'b0;
    logic                  o_stall;
    logic [7:0]            i_rx_byte   = '0;
    logic                  o_valid;
    logic                  i_stall     = 1'b0;
    logic [1:0]            o_event_kind;
    logic [7:0]            o_payload_byte;
    logic                  o_status_frame;
    logic [15:0]           o_payload_length;
    logic                  o_frame_last;

    // predictor state and register copy
    t_cfg        cfg_model;
    t_phase      parse_phase;
    logic [2:0]  status_hits;
    logic [2:0]  command_hits;
    logic [2:0]  footer_hits;
    logic        cur_status;
    logic [15:0] cur_length;
    logic [15:0] payload_seen;
    t_result     pending_results[$];
    int unsigned mismatch_count = 0;

    // stimulus control
    logic        gaps_on     = 1'b1;
    int          burst_left  = 0;
    int          frame_words = 0;
    t_rx_mode    stall_mode  = RX_FREE;
    logic        hold_req    = 1'b0;
    logic        hold_ack    = 1'b0;
    int          hold_left   = 0;
    logic [3:0]  stall_tick  = '0;
    int          idle_cycles = 0;

    dual_marker_frame_deframer uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_rx_byte        (i_rx_byte),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_event_kind     (o_event_kind),
        .o_payload_byte   (o_payload_byte),
        .o_status_frame   (o_status_frame),
        .o_payload_length (o_payload_length),
        .o_frame_last     (o_frame_last)
    );

    always #5 i_clk = ~i_clk;

    // byte pos of a marker, first received byte in the low bits
    function automatic logic [7:0] marker_at(logic [31:0] marker, logic [2:0] pos);
        return marker[8*pos[1:0] +: 8];
    endfunction

    // enter a phase with all frame bookkeeping cleared
    function automatic void clear_frame(t_phase to_phase);
        parse_phase  = to_phase;
        status_hits  = '0;
        command_hits = '0;
        footer_hits  = '0;
        cur_status   = 1'b0;
        cur_length   = '0;
        payload_seen = '0;
    endfunction

    function automatic void push_result(t_event kind, logic [7:0] data, logic last);
        t_result r;
        r.kind           = kind;
        r.payload_byte   = data;
        r.status_frame   = cur_status;
        r.payload_length = cur_length;
        r.frame_last     = last;
        pending_results = {pending_results, r};
    endfunction

    // advance the deframer state by one received byte, queueing any result word
    function automatic void deframe_byte(logic [7:0] b);
        logic [31:0] footer;
        case (parse_phase)
            PH_LEN_A: begin
                cur_length  = cfg_model.length_le ? {8'h00, b} : {b, 8'h00};
                parse_phase = PH_LEN_B;
            end
            PH_LEN_B: begin
                cur_length   = cur_length | (cfg_model.length_le ? {b, 8'h00} : {8'h00, b});
                payload_seen = '0;
                parse_phase  = (cur_length == 16'd0) ? PH_END : PH_DATA;
            end
            PH_DATA: begin
                payload_seen = payload_seen + 16'd1;
                if (payload_seen == cur_length) parse_phase = PH_END;
                push_result(EV_PAYLOAD, b, 1'b0);
            end
            PH_END: begin
                footer = cur_status ? cfg_model.status_end : cfg_model.command_end;
                if (footer_hits < MARKER_LEN && b == marker_at(footer, footer_hits)) begin
                    footer_hits = footer_hits + 3'd1;
                    if (footer_hits >= MARKER_LEN) begin
                        push_result(EV_COMPLETE, 8'h00, 1'b1);
                        clear_frame(PH_HUNT);
                    end
                end else begin
                    // bad end byte is consumed, no marker search on it
                    push_result(EV_DROPPED, 8'h00, 1'b1);
                    clear_frame(PH_HUNT);
                end
            end
            default: begin
                // status marker has priority, a miss clears both counts
                if (status_hits < MARKER_LEN &&
                    b == marker_at(cfg_model.status_start, status_hits)) begin
                    status_hits  = status_hits + 3'd1;
                    command_hits = '0;
                    if (status_hits >= MARKER_LEN) begin
                        clear_frame(PH_LEN_A);
                        cur_status = 1'b1;
                    end
                end else if (command_hits < MARKER_LEN &&
                             b == marker_at(cfg_model.command_start, command_hits)) begin
                    command_hits = command_hits + 3'd1;
                    status_hits  = '0;
                    if (command_hits >= MARKER_LEN) begin
                        clear_frame(PH_LEN_A);
                        cur_status = 1'b0;
                    end
                end else begin
                    status_hits  = '0;
                    command_hits = '0;
                end
            end
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want_val);
        if (mismatch_count < 100)
            $display("%0t: mismatch in %s: got %0h, want %0h", $realtime, what, got, want_val);
        mismatch_count++;
    endtask

    // register write, write enable lowered again before the task returns
    task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [31:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (index)
            REG_STATUS_START:  cfg_model.status_start  = data;
            REG_STATUS_END:    cfg_model.status_end    = data;
            REG_COMMAND_START: cfg_model.command_start = data;
            REG_COMMAND_END:   cfg_model.command_end   = data;
            REG_LENGTH_LE:     cfg_model.length_le     = data[0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // all registers, then a write to an unused index that must be ignored
    task automatic load_setup(t_cfg setup);
        logic [CFG_IDX_W-1:0] stray;
        write_reg(REG_STATUS_START, setup.status_start);
        write_reg(REG_STATUS_END, setup.status_end);
        write_reg(REG_COMMAND_START, setup.command_start);
        write_reg(REG_COMMAND_END, setup.command_end);
        write_reg(REG_LENGTH_LE, {31'd0, setup.length_le});
        stray = REG_LENGTH_LE + 3'd1 + 3'($urandom_range(0, 2));
        write_reg(stray, $urandom());
    endtask

    // offer one word in bursts, with random gaps when enabled, hold it until accepted
    task automatic send_word(logic [7:0] data);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (gaps_on) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
        burst_left--;
        frame_words++;
        i_valid   <= 1'b1;
        i_rx_byte <= data;
        do @(posedge i_clk); while (o_stall);
        deframe_byte(data);
    endtask

    task automatic send_marker(logic [31:0] marker, int count);
        for (int k = 0; k < count; k++) send_word(marker_at(marker, 3'(k)));
    endtask

    task automatic send_length(logic [15:0] len);
        if (cfg_model.length_le) begin
            send_word(len[7:0]);
            send_word(len[15:8]);
        end else begin
            send_word(len[15:8]);
            send_word(len[7:0]);
        end
    endtask

    // stop offering, wait for every expected word, then let the pipeline empty
    task automatic settle();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        burst_left = 0;
    endtask

    // mostly well formed frames with random content, some noise and broken markers
    task automatic send_random_frame();
        logic        as_status;
        logic [31:0] opener;
        logic [31:0] closer;
        logic [15:0] len;
        int          pick;
        int          cut;
        int          noise;
        as_status = 1'($urandom_range(0, 1));
        opener    = as_status ? cfg_model.status_start : cfg_model.command_start;
        closer    = as_status ? cfg_model.status_end : cfg_model.command_end;
        noise     = $urandom_range(0, 2);
        repeat (noise) send_word(8'($urandom_range(0, 255)));
        frame_words -= noise;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            // partial start marker broken by a wrong byte
            cut = $urandom_range(1, MARKER_LEN - 1);
            send_marker(opener, cut);
            send_word(marker_at(opener, 3'(cut)) ^ 8'($urandom_range(1, 255)));
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 6)       len = 16'd0;
            else if (pick < 94) len = 16'($urandom_range(1, 12));
            else                len = 16'($urandom_range(13, 300));
            send_marker(opener, MARKER_LEN);
            send_length(len);
            repeat (len) send_word(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 99) < 75) begin
                send_marker(closer, MARKER_LEN);
            end else begin
                cut = $urandom_range(0, MARKER_LEN - 1);
                send_marker(closer, cut);
                send_word(marker_at(closer, 3'(cut)) ^ 8'(1 << $urandom_range(0, 7)));
            end
        end
    endtask

    task automatic test_directed_frames();
        // a miss inside a start marker is not retried as its first byte
        send_word(marker_at(cfg_model.status_start, 0));
        send_word(marker_at(cfg_model.status_start, 1));
        send_marker(cfg_model.status_start, MARKER_LEN);
        // zero length status frame goes straight to its end marker
        send_marker(cfg_model.status_start, MARKER_LEN);
        send_length(16'd0);
        send_marker(cfg_model.status_end, MARKER_LEN);
        settle();
    endtask

    task automatic test_length_order_switch();
        // byte order follows the register at each length byte
        send_marker(cfg_model.command_start, MARKER_LEN);
        send_word(8'h00);
        settle();
        write_reg(REG_LENGTH_LE, 32'd0);
        send_word(8'h01);
        send_word(8'hFF);
        // bad first end byte drops the frame
        send_word(marker_at(cfg_model.command_end, 0) ^ 8'h80);
        settle();
    endtask

    task automatic test_output_backpressure();
        // receiver holds off while the sender keeps offering words
        gaps_on = 1'b0;
        hold_req <= ~hold_req;
        send_marker(cfg_model.status_start, MARKER_LEN);
        send_length(16'd120);
        repeat (120) send_word(8'($urandom_range(0, 255)));
        send_marker(cfg_model.status_end, MARKER_LEN);
        settle();
        gaps_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        t_cfg setup;
        for (int s = 0; s < TRAFFIC_SETUPS; s++) begin
            case (s)
                0: begin
                    setup = '{$urandom(), $urandom(), $urandom(), $urandom(), 1'b1};
                    stall_mode <= RX_RANDOM;
                end
                1: begin
                    setup = '{$urandom(), $urandom(), $urandom(), $urandom(), 1'b0};
                    stall_mode <= RX_PATTERN;
                end
                2: begin
                    // all-zero and all-one markers, no idling on either side
                    setup = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1};
                    stall_mode <= RX_FREE;
                end
                3: begin
                    // start markers share their first three bytes
                    setup.status_start  = $urandom();
                    setup.command_start = {8'($urandom()), setup.status_start[23:0]};
                    setup.status_end    = $urandom();
                    setup.command_end   = setup.status_end;
                    setup.length_le     = 1'b0;
                    stall_mode <= RX_HEAVY;
                end
                default: begin
                    setup = '{STATUS_START_RST, STATUS_END_RST, COMMAND_START_RST,
                              COMMAND_END_RST, LENGTH_LE_RST};
                    stall_mode <= RX_RANDOM;
                end
            endcase
            load_setup(setup);
            gaps_on     = (s != 2);
            frame_words = 0;
            while (frame_words < RANDOM_WORDS / TRAFFIC_SETUPS) send_random_frame();
            settle();
        end
        gaps_on = 1'b1;
    endtask

    task automatic test_long_frame();
        // length with the top bit set, big endian; the frame stays open after
        // its first payload bytes
        write_reg(REG_LENGTH_LE, 32'd0);
        gaps_on = 1'b0;
        stall_mode <= RX_PATTERN;
        send_marker(cfg_model.command_start, MARKER_LEN);
        send_length(16'h8001);
        repeat (LONG_PART) send_word(8'($urandom_range(0, 255)));
        settle();
    endtask

    // receiver stall: a long hold on request, otherwise the current pattern
    always @(posedge i_clk) begin
        stall_tick <= stall_tick + 4'd1;
        if (hold_req != hold_ack) begin
            hold_ack  <= hold_req;
            hold_left <= LONG_HOLD;
            i_stall   <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else begin
            case (stall_mode)
                RX_FREE:    i_stall <= 1'b0;
                RX_RANDOM:  i_stall <= ($urandom_range(0, 3) == 0);
                RX_PATTERN: i_stall <= (stall_tick < 4'd5);
                default:    i_stall <= ($urandom_range(0, 9) < 7);
            endcase
        end
    end

    // compare each accepted result word with the oldest expected one
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result word", o_event_kind, 32'd0);
            end else begin
                want = pending_results.pop_front();
                if (o_event_kind !== want.kind)
                    report_mismatch("event_kind", o_event_kind, want.kind);
                if (o_payload_byte !== want.payload_byte)
                    report_mismatch("payload_byte", o_payload_byte, want.payload_byte);
                if (o_status_frame !== want.status_frame)
                    report_mismatch("status_frame", o_status_frame, want.status_frame);
                if (o_payload_length !== want.payload_length)
                    report_mismatch("payload_length", o_payload_length, want.payload_length);
                if (o_frame_last !== want.frame_last)
                    report_mismatch("frame_last", o_frame_last, want.frame_last);
            end
        end
    end

    // watchdog on cycles without any accepted word
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin
        cfg_model = '{STATUS_START_RST, STATUS_END_RST, COMMAND_START_RST,
                      COMMAND_END_RST, LENGTH_LE_RST};
        clear_frame(PH_HUNT);
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_frames();
        test_length_order_switch();
        test_output_backpressure();
        test_random_traffic();
        test_long_frame();

        if (mismatch_count == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/dmfd_pkg.sv
src/dmfd_cfg_regs.sv
src/dmfd_parser.sv
src/dmfd_out_reg.sv
src/dual_marker_frame_deframer.sv
test/dual_marker_frame_deframer_tb.sv
